// File: rtl/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg
// Shared types, constants and round functions of the SHA-256 byte stream
// hasher: initial chaining values, round constants, controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package sbsh_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned FILL_W   = 6;
	localparam int unsigned COUNT_W  = 61;
	localparam int unsigned ROUND_W  = 6;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned HASH_WORDS = 8;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [FILL_W-1:0] LEN_POS = 6'd56;
	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
	localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

	typedef logic [1:0] byte_sel_t;
	localparam byte_sel_t BSEL_IN   = 2'd0;
	localparam byte_sel_t BSEL_MARK = 2'd1;
	localparam byte_sel_t BSEL_ZERO = 2'd2;
	localparam byte_sel_t BSEL_LEN  = 2'd3;

	localparam logic [WORD_W-1:0] SBSH_IV [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] SBSH_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic                byte_go;
		byte_sel_t           byte_sel;
		logic                count_inc;
		logic                load_work;
		logic                round_go;
		logic [ROUND_W-1:0]  round_idx;
		logic                chain_add;
		logic                digest_load;
	} sbsh_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              out_busy;
	} sbsh_sts_t;

	function automatic logic [WORD_W-1:0] sbsh_rotr(input logic [WORD_W-1:0] x,
			input int unsigned n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] sbsh_big0(input logic [WORD_W-1:0] x);
		return sbsh_rotr(x, 2) ^ sbsh_rotr(x, 13) ^ sbsh_rotr(x, 22);
	endfunction

	function automatic logic [WORD_W-1:0] sbsh_big1(input logic [WORD_W-1:0] x);
		return sbsh_rotr(x, 6) ^ sbsh_rotr(x, 11) ^ sbsh_rotr(x, 25);
	endfunction

	function automatic logic [WORD_W-1:0] sbsh_sm0(input logic [WORD_W-1:0] x);
		return sbsh_rotr(x, 7) ^ sbsh_rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] sbsh_sm1(input logic [WORD_W-1:0] x);
		return sbsh_rotr(x, 17) ^ sbsh_rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

`default_nettype wire

// File: rtl/sbsh_if.sv
// ----------------------------------------------------------------------------
// sbsh_if
// Valid/ready channels of the SHA-256 byte stream hasher: the message byte
// channel and the digest word channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbsh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_end;

	modport source (output valid, data_byte, byte_valid, message_end, input ready);
	modport sink (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sbsh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// File: rtl/sbsh_ctrl.sv
// ----------------------------------------------------------------------------
// sbsh_ctrl
// Controller of the SHA-256 byte stream hasher: takes input bytes, sequences
// the 64 compression rounds, generates the padding bytes and hands the
// finished digest to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsh_ctrl
	import sbsh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      byte_valid,
	input  wire logic      message_end,
	input  wire sbsh_sts_t sts,
	output sbsh_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q, state_d;
	logic [ROUND_W-1:0] rnd_q, rnd_d;
	logic               end_q, end_d;
	logic               mark_q, mark_d;
	logic               lenok_q, lenok_d;
	logic               fin_q, fin_d;
	logic               block_full;

	assign block_full = (sts.fill == FILL_LAST);

	always_comb begin
		state_d  = state_q;
		rnd_d    = rnd_q;
		end_d    = end_q;
		mark_d   = mark_q;
		lenok_d  = lenok_q;
		fin_d    = fin_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.byte_sel  = BSEL_IN;
		cmd.round_idx = rnd_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (byte_valid) begin
						cmd.byte_go   = 1'b1;
						cmd.count_inc = 1'b1;
					end
					if (byte_valid && block_full) begin
						end_d   = message_end;
						state_d = ST_START;
					end else if (message_end) begin
						end_d   = 1'b1;
						state_d = ST_PAD;
					end
				end
			end
			ST_START: begin
				cmd.load_work = 1'b1;
				rnd_d   = '0;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_go = 1'b1;
				rnd_d = rnd_q + 1'b1;
				if (rnd_q == ROUND_LAST) begin
					cmd.chain_add = 1'b1;
					lenok_d = mark_q;
					if (fin_q) begin
						state_d = ST_DONE;
					end else if (end_q) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				cmd.byte_go = 1'b1;
				if (!mark_q) begin
					cmd.byte_sel = BSEL_MARK;
					mark_d  = 1'b1;
					lenok_d = (sts.fill < LEN_POS);
				end else if (lenok_q && sts.fill >= LEN_POS) begin
					cmd.byte_sel = BSEL_LEN;
				end else begin
					cmd.byte_sel = BSEL_ZERO;
				end
				if (block_full) begin
					fin_d   = mark_q && lenok_q;
					state_d = ST_START;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.digest_load = 1'b1;
					end_d   = 1'b0;
					mark_d  = 1'b0;
					lenok_d = 1'b0;
					fin_d   = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			end_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenok_q <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
			end_q   <= end_d;
			mark_q  <= mark_d;
			lenok_q <= lenok_d;
			fin_q   <= fin_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sbsh_dp.sv
// ----------------------------------------------------------------------------
// sbsh_dp
// Datapath of the SHA-256 byte stream hasher: block shift register that
// doubles as the message schedule window, round logic, chaining values,
// byte counter and the digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsh_dp
	import sbsh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sbsh_cmd_t   cmd,
	input  wire logic [7:0]  in_byte,
	output sbsh_sts_t        sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [WORD_W-1:0] digest_word,
	output logic [IDX_W-1:0] word_index,
	output logic             last_word
);

	logic [WORD_W-1:0]  blk_q   [BLK_WORDS];
	logic [WORD_W-1:0]  work_q  [HASH_WORDS];
	logic [WORD_W-1:0]  chain_q [HASH_WORDS];
	logic [WORD_W-1:0]  dig_q   [HASH_WORDS];
	logic [FILL_W-1:0]  fill_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovld_q;
	logic [IDX_W-1:0]   oidx_q;

	logic [WORD_W-1:0]  work_nx [HASH_WORDS];
	logic [WORD_W-1:0]  t1, t2, ch, mj, w_new;
	logic [63:0]        len_bits;
	logic [5:0]         len_sh;
	logic [7:0]         len_byte, byte_d;
	logic               out_take;

	assign len_bits = {count_q, 3'b000};
	assign len_sh   = {~fill_q[2:0], 3'b000};
	assign len_byte = 8'(len_bits >> len_sh);

	always_comb begin
		case (cmd.byte_sel)
			BSEL_IN:   byte_d = in_byte;
			BSEL_MARK: byte_d = PAD_MARK;
			BSEL_ZERO: byte_d = 8'h00;
			BSEL_LEN:  byte_d = len_byte;
			default:   byte_d = 8'h00;
		endcase
	end

	// one round and one schedule word
	assign ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1 = work_q[7] + sbsh_big1(work_q[4]) + ch + SBSH_K[cmd.round_idx] + blk_q[0];
	assign t2 = sbsh_big0(work_q[0]) + mj;
	assign w_new = sbsh_sm1(blk_q[14]) + blk_q[9] + sbsh_sm0(blk_q[1]) + blk_q[0];

	always_comb begin
		work_nx[0] = t1 + t2;
		work_nx[1] = work_q[0];
		work_nx[2] = work_q[1];
		work_nx[3] = work_q[2];
		work_nx[4] = work_q[3] + t1;
		work_nx[5] = work_q[4];
		work_nx[6] = work_q[5];
		work_nx[7] = work_q[6];
	end

	assign out_take = ovld_q && out_ready;

	always_ff @(posedge clk) begin
		if (cmd.byte_go) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
			end
			blk_q[BLK_WORDS-1] <= {blk_q[BLK_WORDS-1][23:0], byte_d};
		end else if (cmd.round_go) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				blk_q[i] <= blk_q[i+1];
			end
			blk_q[BLK_WORDS-1] <= w_new;
		end
		if (cmd.load_work) begin
			work_q <= chain_q;
		end else if (cmd.round_go) begin
			work_q <= work_nx;
		end
		if (cmd.digest_load) begin
			dig_q <= chain_q;
		end else if (out_take) begin
			for (int i = 0; i < HASH_WORDS - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
			dig_q[HASH_WORDS-1] <= dig_q[HASH_WORDS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= SBSH_IV;
			fill_q  <= '0;
			count_q <= '0;
			ovld_q  <= 1'b0;
			oidx_q  <= '0;
		end else begin
			if (cmd.digest_load) begin
				chain_q <= SBSH_IV;
				fill_q  <= '0;
				count_q <= '0;
				ovld_q  <= 1'b1;
				oidx_q  <= '0;
			end else begin
				if (cmd.chain_add) begin
					for (int i = 0; i < HASH_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + work_nx[i];
					end
				end
				if (cmd.byte_go) begin
					fill_q <= fill_q + 1'b1;
				end
				if (cmd.count_inc) begin
					count_q <= count_q + 1'b1;
				end
				if (out_take) begin
					oidx_q <= oidx_q + 1'b1;
					if (oidx_q == IDX_LAST) begin
						ovld_q <= 1'b0;
					end
				end
			end
		end
	end

	assign sts.fill     = fill_q;
	assign sts.out_busy = ovld_q;
	assign out_valid    = ovld_q;
	assign digest_word  = dig_q[0];
	assign word_index   = oidx_q;
	assign last_word    = (oidx_q == IDX_LAST);

endmodule

`default_nettype wire

// File: rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest returned as eight 32-bit words.
//
// msg carries one byte per handshake: data_byte with byte_valid, and
// message_end to close the message. digest returns the eight digest words,
// word_index 0 first, last_word set on the eighth.
// The 64th byte of a block starts the compression: a load step and 64
// rounds, one per cycle on a single round unit, with msg.ready low
// throughout, so no byte is taken while a block is compressed. On
// message_end the controller feeds the 0x80 mark, zero bytes and the
// eight length bytes one per cycle, then compresses.
// The digest sits in its own output register, so the next message is taken
// while it drains; a second digest waits until the first has gone out.
// A stall on digest holds the current word; a message finished meanwhile
// waits in the controller with msg.ready low.
// After reset the chaining values are the standard initial values and the
// byte and fill counters are zero; the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher
	import sbsh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sbsh_in_if.sink   msg,
	sbsh_out_if.source digest
);

	sbsh_cmd_t cmd;
	sbsh_sts_t sts;

	sbsh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (msg.valid),
		.in_ready    (msg.ready),
		.byte_valid  (msg.byte_valid),
		.message_end (msg.message_end),
		.sts         (sts),
		.cmd         (cmd)
	);

	sbsh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_byte     (msg.data_byte),
		.sts         (sts),
		.out_valid   (digest.valid),
		.out_ready   (digest.ready),
		.digest_word (digest.digest_word),
		.word_index  (digest.word_index),
		.last_word   (digest.last_word)
	);

	a_full_block_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid && msg.ready && msg.byte_valid && sts.fill == FILL_LAST |=> !msg.ready)
		else $error("input still taken after the block filled");

	a_compress_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_work |-> sts.fill == '0)
		else $error("compression started on a partial block");

	a_digest_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digest_load |-> !digest.valid)
		else $error("digest loaded over an undelivered digest");

	a_digest_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digest_load |=> digest.valid && digest.word_index == '0)
		else $error("digest output did not start at word 0");

endmodule

`default_nettype wire
